[src/dtpp_pkg.sv]
// Shared types and constants of the depth-to-point projection block.
`default_nettype none

package dtpp_pkg;

  // Field widths of the pixel, the point and the registers.
  localparam int unsigned DEPTH_W    = 16;
  localparam int unsigned COLOUR_W   = 8;
  localparam int unsigned FRAME_W_W  = 13;
  localparam int unsigned FRAME_H_W  = 12;
  localparam int unsigned CENTER_X_W = 16;
  localparam int unsigned CENTER_Y_W = 15;
  localparam int unsigned INV_W      = 24;
  localparam int unsigned POINT_W    = 40;
  localparam int unsigned FRAC_DROP  = 20;
  // Compare width for frame sizes against the maximum sizes (up to 8192).
  localparam int unsigned SIZE_CMP_W = 14;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // Stream packing.
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 120;
  localparam int unsigned OUT_TUSER_W = 2;

  // Register reset values.
  localparam logic [FRAME_W_W-1:0]  FRAME_W_RST  = 13'd1920;
  localparam logic [FRAME_H_W-1:0]  FRAME_H_RST  = 12'd1080;
  localparam logic [CENTER_X_W-1:0] CENTER_X_RST = 16'd15360;
  localparam logic [CENTER_Y_W-1:0] CENTER_Y_RST = 15'd8640;
  localparam logic [INV_W-1:0]      INV_RST      = 24'd16777;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_CENTER_X     = 3'd2,
    REG_CENTER_Y     = 3'd3,
    REG_INV_FOCAL_X  = 3'd4,
    REG_INV_FOCAL_Y  = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [FRAME_W_W-1:0]  frame_width;
    logic [FRAME_H_W-1:0]  frame_height;
    logic [CENTER_X_W-1:0] center_x;
    logic [CENTER_Y_W-1:0] center_y;
    logic [INV_W-1:0]      inv_focal_x;
    logic [INV_W-1:0]      inv_focal_y;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_ROUND,
    ST_OUT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic mul1;
    logic mul2;
    logic rnd;
    logic load_out;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

[src/dtpp_cfg_regs.sv]
// Configuration register file of the depth-to-point projection block.
`default_nettype none

module dtpp_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output      logic                           cfg_ready_o,
  input  wire logic [dtpp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [dtpp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output      dtpp_pkg::cfg_t                 cfg_o
);
  import dtpp_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Writes are always taken; unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_FRAME_WIDTH:  cfg_d.frame_width  = cfg_data_i[FRAME_W_W-1:0];
        REG_FRAME_HEIGHT: cfg_d.frame_height = cfg_data_i[FRAME_H_W-1:0];
        REG_CENTER_X:     cfg_d.center_x     = cfg_data_i[CENTER_X_W-1:0];
        REG_CENTER_Y:     cfg_d.center_y     = cfg_data_i[CENTER_Y_W-1:0];
        REG_INV_FOCAL_X:  cfg_d.inv_focal_x  = cfg_data_i[INV_W-1:0];
        REG_INV_FOCAL_Y:  cfg_d.inv_focal_y  = cfg_data_i[INV_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width  <= FRAME_W_RST;
      cfg_q.frame_height <= FRAME_H_RST;
      cfg_q.center_x     <= CENTER_X_RST;
      cfg_q.center_y     <= CENTER_Y_RST;
      cfg_q.inv_focal_x  <= INV_RST;
      cfg_q.inv_focal_y  <= INV_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[src/dtpp_ctrl.sv]
// Sequencing state machine of the depth-to-point projection block.
`default_nettype none

module dtpp_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_tvalid_i,
  output      logic                 s_tready_o,
  input  wire dtpp_pkg::dp_status_t status_i,
  output      dtpp_pkg::dp_cmd_t    cmd_o
);
  import dtpp_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = ST_ROUND;
      end
      ST_ROUND: begin
        cmd_o.rnd = 1'b1;
        state_d   = ST_OUT;
      end
      ST_OUT: begin
        // Wait here until the output register can take the point.
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_capture_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o) |=> (state_q == ST_MUL1))
    else $error("accepted pixel did not start the multiply sequence");

  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && !status_i.out_free) |=> (state_q == ST_OUT))
    else $error("finished point left the sequencer while output was full");
`endif

endmodule

`default_nettype wire

[src/dtpp_datapath.sv]
// Pixel counters, projection arithmetic and output register.
`default_nettype none

module dtpp_datapath #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 2048
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire dtpp_pkg::cfg_t                   cfg_i,
  input  wire dtpp_pkg::dp_cmd_t                cmd_i,
  output      dtpp_pkg::dp_status_t             status_o,
  input  wire logic [dtpp_pkg::IN_TDATA_W-1:0]  s_tdata_i,
  input  wire logic                             s_tuser_i,
  output      logic                             m_tvalid_o,
  input  wire logic                             m_tready_i,
  output      logic [dtpp_pkg::OUT_TDATA_W-1:0] m_tdata_o,
  output      logic                             m_tlast_o,
  output      logic [dtpp_pkg::OUT_TUSER_W-1:0] m_tuser_o
);
  import dtpp_pkg::*;

  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned RW  = $clog2(MAX_HEIGHT);
  localparam int unsigned PW  = (CW > RW) ? CW : RW;
  // Offset magnitude: positive side below 2^(PW+4), negative side below 2^16.
  localparam int unsigned MW  = (PW + 4 > CENTER_X_W) ? PW + 4 : CENTER_X_W;
  localparam int unsigned OW  = MW + 1;
  localparam int unsigned P1W = MW + INV_W;
  localparam int unsigned P2W = P1W + DEPTH_W;
  localparam int unsigned QW  = P2W + 1 - FRAC_DROP;
  localparam int unsigned EW  = (QW > POINT_W + 1) ? QW : POINT_W + 1;
  localparam logic [EW-1:0] SAT_POS_E = EW'({1'b0, {(POINT_W-1){1'b1}}});
  localparam logic [EW-1:0] SAT_NEG_E = EW'({1'b1, {(POINT_W-1){1'b0}}});
  localparam logic [P2W:0]  HALF_LSB  = (P2W+1)'(1) << (FRAC_DROP - 1);

  // Rounded magnitude to signed 40-bit point coordinate with saturation.
  function automatic logic [POINT_W-1:0] to_point(input logic [QW-1:0] q,
                                                  input logic neg);
    logic [EW-1:0]      qe;
    logic [EW-1:0]      ne;
    logic [POINT_W-1:0] res;
    qe = EW'(q);
    ne = -qe;
    if (neg) begin
      res = (qe > SAT_NEG_E) ? SAT_NEG_E[POINT_W-1:0] : ne[POINT_W-1:0];
    end else begin
      res = (qe > SAT_POS_E) ? SAT_POS_E[POINT_W-1:0] : qe[POINT_W-1:0];
    end
    return res;
  endfunction

  // Input beat fields.
  logic [DEPTH_W-1:0]  in_depth;
  logic [COLOUR_W-1:0] in_blue, in_green, in_red;
  logic                in_valid;

  assign in_depth = s_tdata_i[15:0];
  assign in_blue  = s_tdata_i[23:16];
  assign in_green = s_tdata_i[31:24];
  assign in_red   = s_tdata_i[39:32];
  assign in_valid = (in_depth != '0) && !s_tuser_i;

  // Pixel position counters and frame density.
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic          dense_q, dense_d;

  logic [SIZE_CMP_W-1:0] fw_ext, fh_ext;
  logic [CW:0]           width_c;
  logic [RW:0]           height_c;
  logic                  last_col, last_row, fend, pix_dense;

  // Frame sizes clamped to one..maximum.
  always_comb begin
    fw_ext = SIZE_CMP_W'(cfg_i.frame_width);
    fh_ext = SIZE_CMP_W'(cfg_i.frame_height);
    if (fw_ext == '0) begin
      width_c = (CW+1)'(1);
    end else if (fw_ext > SIZE_CMP_W'(MAX_WIDTH)) begin
      width_c = (CW+1)'(MAX_WIDTH);
    end else begin
      width_c = fw_ext[CW:0];
    end
    if (fh_ext == '0) begin
      height_c = (RW+1)'(1);
    end else if (fh_ext > SIZE_CMP_W'(MAX_HEIGHT)) begin
      height_c = (RW+1)'(MAX_HEIGHT);
    end else begin
      height_c = fh_ext[RW:0];
    end
  end

  assign last_col  = ((CW+1)'(col_q) + (CW+1)'(1)) >= width_c;
  assign last_row  = ((RW+1)'(row_q) + (RW+1)'(1)) >= height_c;
  assign fend      = last_col && last_row;
  assign pix_dense = dense_q && in_valid;

  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    dense_d = dense_q;
    if (cmd_i.capture) begin
      if (fend) begin
        col_d   = '0;
        row_d   = '0;
        dense_d = 1'b1;
      end else begin
        dense_d = pix_dense;
        if (last_col) begin
          col_d = '0;
          row_d = row_q + RW'(1);
        end else begin
          col_d = col_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      dense_q <= 1'b1;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      dense_q <= dense_d;
    end
  end

  // Pixel-centre offsets in Q.4: pos*16 + 8 - centre, as sign and magnitude.
  logic [OW-1:0] offx, offy, negoffx, negoffy;

  assign offx    = OW'({PW'(col_q), 4'b1000}) - OW'(cfg_i.center_x);
  assign offy    = OW'({PW'(row_q), 4'b1000}) - OW'(cfg_i.center_y);
  assign negoffx = -offx;
  assign negoffy = -offy;

  // Capture stage.
  logic [MW-1:0]       magx_q, magy_q;
  logic                negx_q, negy_q;
  logic [DEPTH_W-1:0]  depth_q;
  logic [COLOUR_W-1:0] blue_q, green_q, red_q;
  logic                valid_q, fend_q, fdense_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      negx_q   <= offx[OW-1];
      negy_q   <= offy[OW-1];
      magx_q   <= offx[OW-1] ? negoffx[MW-1:0] : offx[MW-1:0];
      magy_q   <= offy[OW-1] ? negoffy[MW-1:0] : offy[MW-1:0];
      depth_q  <= in_depth;
      blue_q   <= in_blue;
      green_q  <= in_green;
      red_q    <= in_red;
      valid_q  <= in_valid;
      fend_q   <= fend;
      fdense_q <= fend && pix_dense;
    end
  end

  // Offset times reciprocal focal length, then times depth.
  logic [P1W-1:0] p1x_q, p1y_q;
  logic [P2W-1:0] p2x_q, p2y_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul1) begin
      p1x_q <= P1W'(magx_q) * P1W'(cfg_i.inv_focal_x);
      p1y_q <= P1W'(magy_q) * P1W'(cfg_i.inv_focal_y);
    end
    if (cmd_i.mul2) begin
      p2x_q <= P2W'(p1x_q) * P2W'(depth_q);
      p2y_q <= P2W'(p1y_q) * P2W'(depth_q);
    end
  end

  // Drop the Q20 fraction, rounding half away from zero on the magnitude.
  logic [P2W:0]  sumx, sumy;
  logic [QW-1:0] q8x_q, q8y_q;

  assign sumx = (P2W+1)'(p2x_q) + HALF_LSB;
  assign sumy = (P2W+1)'(p2y_q) + HALF_LSB;

  always_ff @(posedge clk_i) begin
    if (cmd_i.rnd) begin
      q8x_q <= sumx[P2W:FRAC_DROP];
      q8y_q <= sumy[P2W:FRAC_DROP];
    end
  end

  // Output register: one point waits here while the next pixel is worked on.
  logic                   out_valid_q, out_valid_d;
  logic [OUT_TDATA_W-1:0] out_data_q;
  logic                   out_last_q;
  logic [OUT_TUSER_W-1:0] out_user_q;
  logic [OUT_TDATA_W-1:0] point_data;

  assign status_o.out_free = !out_valid_q || m_tready_i;

  always_comb begin
    if (valid_q) begin
      point_data = {red_q, green_q, blue_q, depth_q,
                    to_point(q8y_q, negy_q), to_point(q8x_q, negx_q)};
    end else begin
      point_data = '0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_data_q <= point_data;
      out_last_q <= fend_q;
      out_user_q <= {fdense_q, valid_q};
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;
  assign m_tlast_o  = out_last_q;
  assign m_tuser_o  = out_user_q;

`ifndef SYNTHESIS
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && !m_tuser_o[0]) |-> (m_tdata_o == '0))
    else $error("invalid point carries non-zero fields");

  a_dense_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_o && m_tuser_o[1]) |-> (m_tlast_o && m_tuser_o[0]))
    else $error("dense flag outside a valid frame-end point");
`endif

endmodule

`default_nettype wire

[src/depth_to_point_projection.sv]
// Top level of the depth-to-point projection block.
//
// Pixels of a depth image arrive in raster order on the slave stream, one
// per beat: depth in millimetres, a sensor invalid flag on tuser, and a
// blue, green, red triple. Each pixel gives exactly one point on
// the master stream: X and Y in signed Q8 millimetres from the pinhole
// model, Z as the depth, the colour, a valid flag and, on the last pixel of
// a frame (tlast), whether every pixel of that frame was valid.
// Registers are written on the configuration channel, which is always ready;
// write them only while no pixel is in flight.
// After its input beat is accepted, a point passes the capture, product,
// rounding and output registers in turn before the master side sees it.
// The sequencer takes no new pixel until it has walked the current one
// through capture, two multiply steps, rounding and output loading.
// The output register holds one finished point, so the next pixel is taken
// while that point waits; a stalled receiver blocks only the following
// point's final load, and then the slave side waits too.
// Reset returns the registers to their defaults, clears the row and column
// counters, marks the frame dense and empties the output register.
`default_nettype none

module depth_to_point_projection #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 2048
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Slave stream.
  input  wire logic                              s_tvalid_i,
  output      logic                              s_tready_o,
  // depth_mm[15:0], blue[23:16], green[31:24], red[39:32]
  input  wire logic [dtpp_pkg::IN_TDATA_W-1:0]   s_tdata_i,
  // depth_invalid[0]
  input  wire logic                              s_tuser_i,
  // Master stream.
  output      logic                              m_tvalid_o,
  input  wire logic                              m_tready_i,
  // point_x[39:0], point_y[79:40], point_z[95:80], out_blue[103:96],
  // out_green[111:104], out_red[119:112]
  output      logic [dtpp_pkg::OUT_TDATA_W-1:0]  m_tdata_o,
  // frame_end
  output      logic                              m_tlast_o,
  // point_valid[0], frame_dense[1]
  output      logic [dtpp_pkg::OUT_TUSER_W-1:0]  m_tuser_o,
  // Configuration write channel.
  input  wire logic                              cfg_valid_i,
  output      logic                              cfg_ready_o,
  input  wire logic [dtpp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [dtpp_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import dtpp_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  dtpp_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  dtpp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dtpp_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .cmd_i      (cmd),
    .status_o   (status),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tlast_o  (m_tlast_o),
    .m_tuser_o  (m_tuser_o)
  );

endmodule

`default_nettype wire
